### sv/set_assoc_cache_lru_lookup_assert.svh
`ifndef SET_ASSOC_CACHE_LRU_LOOKUP_ASSERT_SVH
`define SET_ASSOC_CACHE_LRU_LOOKUP_ASSERT_SVH

// checked only outside reset
`define SACL_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define SACL_ASSERT_ANY(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/sacl_pkg.sv
package sacl_pkg;

  localparam int WAYS     = 8;
  localparam int WAY_W    = 3;
  localparam int SETS     = 256;
  localparam int SET_W    = 8;
  localparam int ADDR_W   = 32;
  localparam int CNT_W    = 32;
  localparam int AGE_W    = 3;
  localparam int AGE_MAX  = 7;
  localparam int IBITS_W  = 4;
  localparam int OBITS_W  = 5;
  localparam int WIU_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int OUT_W    = 72;

  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

  typedef struct packed {
    logic [WAYS-1:0][AGE_W-1:0] age;
    logic [WAYS-1:0]            valid;
  } row_t;

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] hit_way;
    logic [WAYS-1:0]  use_mask;
  } upd_in_t;

  typedef struct packed {
    logic [WAY_W-1:0] way;
    logic             evicted;
  } upd_out_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_UPDATE = 3'b100
  } state_t;

endpackage

### sv/sacl_ram.sv
module sacl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/sacl_row_update.sv
module sacl_row_update (
  input  sacl_pkg::row_t     row_in,
  input  sacl_pkg::upd_in_t  ctl,
  output sacl_pkg::row_t     row_out,
  output sacl_pkg::upd_out_t res
);

  logic                            empty_found;
  logic [sacl_pkg::WAY_W-1:0]      empty_way;
  logic [sacl_pkg::AGE_W-1:0]      best;
  logic [sacl_pkg::WAY_W-1:0]      victim;
  logic [sacl_pkg::WAY_W-1:0]      target;
  logic [sacl_pkg::AGE_W:0]        limit;

  always_comb begin
    empty_found = 1'b0;
    empty_way   = '0;
    for (int w = sacl_pkg::WAYS - 1; w >= 0; w--) begin
      if (ctl.use_mask[w] && !row_in.valid[w]) begin
        empty_found = 1'b1;
        empty_way   = sacl_pkg::WAY_W'(w);
      end
    end

    best   = '0;
    victim = '0;
    for (int w = 0; w < sacl_pkg::WAYS; w++) begin
      if (ctl.use_mask[w] && row_in.age[w] > best) begin
        best   = row_in.age[w];
        victim = sacl_pkg::WAY_W'(w);
      end
    end

    priority if (ctl.hit) begin
      target = ctl.hit_way;
      limit  = {1'b0, row_in.age[ctl.hit_way]};
    end else if (empty_found) begin
      target = empty_way;
      limit  = (sacl_pkg::AGE_W+1)'(sacl_pkg::AGE_MAX + 1);
    end else begin
      target = victim;
      limit  = {1'b0, best};
    end

    row_out = row_in;
    for (int w = 0; w < sacl_pkg::WAYS; w++) begin
      if (sacl_pkg::WAY_W'(w) == target) begin
        row_out.valid[w] = 1'b1;
        row_out.age[w]   = '0;
      end else if (ctl.use_mask[w] && row_in.valid[w] && ({1'b0, row_in.age[w]} < limit)
                   && (row_in.age[w] != sacl_pkg::AGE_W'(sacl_pkg::AGE_MAX))) begin
        row_out.age[w] = row_in.age[w] + sacl_pkg::AGE_W'(1);
      end
    end

    res.way     = target;
    res.evicted = !ctl.hit && !empty_found;
  end

endmodule

### sv/set_assoc_cache_lru_lookup.sv
// channel  | dir | beat content
// s_       | in  | tdata: address[31:0]
// m_       | out | tdata: hit, way, evicted, access_count, miss_count
// cfg_     | in  | cfg_index selects index_bits, offset_bits, ways_in_use
//
// per item, k = ways compared (1 to ways in use, at most 8 in all);
// the single tag comparator, fed one way a cycle from the tag ram, sets k
// rst is synchronous; clears counters, the per-set valid flags and the sequencer
// sets never touched read as empty; no clearing pass follows reset
// a held result stalls the row update; no new address is taken until that update commits
module set_assoc_cache_lru_lookup (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [sacl_pkg::ADDR_W-1:0]       s_tdata,   // address
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [sacl_pkg::OUT_W-1:0]        m_tdata,   // hit, way, evicted, access_count,
                                                       // miss_count, zero pad
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sacl_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int TAG_DEPTH = sacl_pkg::SETS * sacl_pkg::WAYS;
  localparam int ROW_W     = $bits(sacl_pkg::row_t);

  sacl_pkg::state_t state, state_next;

  logic [sacl_pkg::IBITS_W-1:0] index_bits;
  logic [sacl_pkg::OBITS_W-1:0] offset_bits;
  logic [sacl_pkg::WIU_W-1:0]   ways_in_use;

  logic [sacl_pkg::SET_W-1:0]   set_reg;
  logic [sacl_pkg::ADDR_W-1:0]  tag_reg;
  logic [sacl_pkg::WAY_W-1:0]   n_last;
  logic [sacl_pkg::WAY_W-1:0]   issue_way;
  logic [sacl_pkg::WAY_W-1:0]   cmp_way;
  logic                         hit_reg;
  logic [sacl_pkg::WAY_W-1:0]   hit_way;
  logic [sacl_pkg::SETS-1:0]    row_init;
  logic [sacl_pkg::CNT_W-1:0]   access_total;
  logic [sacl_pkg::CNT_W-1:0]   miss_total;

  logic                         out_hit;
  logic [sacl_pkg::WAY_W-1:0]   out_way;
  logic                         out_evicted;
  logic [sacl_pkg::CNT_W-1:0]   out_access;
  logic [sacl_pkg::CNT_W-1:0]   out_miss;

  logic                         in_beat;
  logic                         commit;
  logic [sacl_pkg::SET_W:0]     one_sh;
  logic [sacl_pkg::SET_W-1:0]   set_mask;
  logic [sacl_pkg::SET_W-1:0]   set_in;
  logic [sacl_pkg::ADDR_W-1:0]  tag_in;
  logic [5:0]                   tag_shift;
  logic [sacl_pkg::ADDR_W-1:0]  idx_shifted;
  logic [sacl_pkg::WAY_W-1:0]   n_last_in;

  logic                         tag_re;
  logic [$clog2(TAG_DEPTH)-1:0] tag_raddr;
  logic [sacl_pkg::ADDR_W-1:0]  tag_rdata;
  logic [ROW_W-1:0]             meta_rdata;

  sacl_pkg::row_t     row_view;
  sacl_pkg::row_t     row_new;
  sacl_pkg::upd_in_t  upd_ctl;
  sacl_pkg::upd_out_t upd_res;

  logic                         tag_match;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == sacl_pkg::ST_IDLE);
  assign in_beat   = s_tvalid && s_tready;
  assign commit    = (state == sacl_pkg::ST_UPDATE) && (!m_tvalid || m_tready);

  // address split
  assign idx_shifted = s_tdata >> offset_bits;
  assign one_sh      = (sacl_pkg::SET_W+1)'(1) << index_bits;
  assign set_mask    = (index_bits >= sacl_pkg::IBITS_W'(sacl_pkg::SET_W)) ? '1 :
                       sacl_pkg::SET_W'(one_sh - (sacl_pkg::SET_W+1)'(1));
  assign set_in      = idx_shifted[sacl_pkg::SET_W-1:0] & set_mask;
  assign tag_shift   = 6'(offset_bits) + 6'(index_bits);
  assign tag_in      = s_tdata >> tag_shift;

  always_comb begin
    if (ways_in_use == '0) begin
      n_last_in = '0;
    end else if (ways_in_use > sacl_pkg::WIU_W'(sacl_pkg::WAYS)) begin
      n_last_in = sacl_pkg::WAY_W'(sacl_pkg::WAYS - 1);
    end else begin
      n_last_in = sacl_pkg::WAY_W'(ways_in_use - sacl_pkg::WIU_W'(1));
    end
  end

  // tag ram: one way a beat during the scan
  assign tag_re    = in_beat || (state == sacl_pkg::ST_SCAN);
  assign tag_raddr = in_beat ? {set_in, sacl_pkg::WAY_W'(0)} : {set_reg, issue_way};

  sacl_ram #(
    .WIDTH (sacl_pkg::ADDR_W),
    .DEPTH (TAG_DEPTH)
  ) u_tag_ram (
    .clk   (clk),
    .we    (commit && !hit_reg),
    .waddr ({set_reg, upd_res.way}),
    .wdata (tag_reg),
    .re    (tag_re),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

  sacl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (sacl_pkg::SETS)
  ) u_meta_ram (
    .clk   (clk),
    .we    (commit),
    .waddr (set_reg),
    .wdata (ROW_W'(row_new)),
    .re    (in_beat),
    .raddr (set_in),
    .rdata (meta_rdata)
  );

  // untouched sets read as all empty, age zero
  assign row_view = row_init[set_reg] ? sacl_pkg::row_t'(meta_rdata) : '0;

  always_comb begin
    for (int w = 0; w < sacl_pkg::WAYS; w++) begin
      upd_ctl.use_mask[w] = (sacl_pkg::WAY_W'(w) <= n_last);
    end
    upd_ctl.hit     = hit_reg;
    upd_ctl.hit_way = hit_way;
  end

  sacl_row_update u_row_update (
    .row_in  (row_view),
    .ctl     (upd_ctl),
    .row_out (row_new),
    .res     (upd_res)
  );

  assign tag_match = row_view.valid[cmp_way] && (tag_rdata == tag_reg);

  always_comb begin
    state_next = state;
    unique case (state)
      sacl_pkg::ST_IDLE: begin
        if (in_beat) begin
          state_next = sacl_pkg::ST_SCAN;
        end
      end
      sacl_pkg::ST_SCAN: begin
        if (tag_match || cmp_way == n_last) begin
          state_next = sacl_pkg::ST_UPDATE;
        end
      end
      sacl_pkg::ST_UPDATE: begin
        if (commit) begin
          state_next = sacl_pkg::ST_IDLE;
        end
      end
      default: state_next = sacl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= sacl_pkg::ST_IDLE;
      index_bits   <= sacl_pkg::IBITS_W'(8);
      offset_bits  <= sacl_pkg::OBITS_W'(3);
      ways_in_use  <= sacl_pkg::WIU_W'(8);
      row_init     <= '0;
      access_total <= '0;
      miss_total   <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          sacl_pkg::CFG_INDEX_BITS:  index_bits  <= cfg_data[sacl_pkg::IBITS_W-1:0];
          sacl_pkg::CFG_OFFSET_BITS: offset_bits <= cfg_data;
          sacl_pkg::CFG_WAYS_IN_USE: ways_in_use <= cfg_data[sacl_pkg::WIU_W-1:0];
          default: ;
        endcase
      end
      if (commit) begin
        row_init[set_reg] <= 1'b1;
        access_total      <= access_total + sacl_pkg::CNT_W'(1);
        if (!hit_reg) begin
          miss_total <= miss_total + sacl_pkg::CNT_W'(1);
        end
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      set_reg   <= set_in;
      tag_reg   <= tag_in;
      n_last    <= n_last_in;
      issue_way <= sacl_pkg::WAY_W'(1);
      cmp_way   <= '0;
      hit_reg   <= 1'b0;
      hit_way   <= '0;
    end else if (state == sacl_pkg::ST_SCAN) begin
      issue_way <= issue_way + sacl_pkg::WAY_W'(1);
      cmp_way   <= cmp_way + sacl_pkg::WAY_W'(1);
      if (tag_match) begin
        hit_reg <= 1'b1;
        hit_way <= cmp_way;
      end
    end
    if (commit) begin
      out_hit     <= hit_reg;
      out_way     <= upd_res.way;
      out_evicted <= upd_res.evicted;
      out_access  <= access_total + sacl_pkg::CNT_W'(1);
      out_miss    <= hit_reg ? miss_total : miss_total + sacl_pkg::CNT_W'(1);
    end
  end

  assign m_tdata = {3'b000, out_miss, out_access, out_evicted, out_way, out_hit};

endmodule

### sv/sacl_checker.sv
`include "set_assoc_cache_lru_lookup_assert.svh"

module sacl_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [sacl_pkg::OUT_W-1:0]   m_tdata
);

  `SACL_ASSERT_RUN(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result beat changed while stalled")
  `SACL_ASSERT_RUN(a_busy_after_in, s_tvalid && s_tready |=> !s_tready, "address taken while a lookup is in progress")
  `SACL_ASSERT_RUN(a_hit_no_evict, m_tvalid |-> !(m_tdata[0] && m_tdata[4]), "eviction flagged on a hit")
  `SACL_ASSERT_ANY(a_reset_empty, rst |=> !m_tvalid, "result beat shown straight after reset")

endmodule

bind set_assoc_cache_lru_lookup sacl_checker u_sacl_checker (.*);
